/* rtl/ofdm_cp_strip_fft_demodulator_macros.svh */
// assertion macros shared by the checker
`ifndef OFDM_CP_STRIP_FFT_DEMODULATOR_MACROS_SVH
`define OFDM_CP_STRIP_FFT_DEMODULATOR_MACROS_SVH

// same-cycle implication, silent during reset
`define OCSFD_AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ocsfd check failed");

// next-cycle implication, silent during reset
`define OCSFD_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ocsfd check failed");

`endif

/* rtl/ocsfd_pkg.sv */
// shared types, constants and twiddle table of the ofdm demodulator
`default_nettype none
package ocsfd_pkg;

	localparam int OUT_W = 23;
	localparam int TP_LOG2 = 6;
	localparam logic [6:0] PREFIX_MAX = 7'd64;

	localparam logic [1:0] CFG_SIZE = 2'd0;
	localparam logic [1:0] CFG_PREFIX = 2'd1;
	localparam logic [1:0] CFG_LAG = 2'd2;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic [5:0] t;
	} tok_t;

	typedef struct packed {
		logic [6:0]        n;
		logic [2:0]        lg;
		logic signed [6:0] lag;
		logic              load;
		logic              shift;
	} cell_ctl_t;

	function automatic logic signed [15:0] quarter_sine(input logic [4:0] r);
		logic signed [15:0] v;
		case (r)
			5'd0:  v = 16'sd0;
			5'd1:  v = 16'sd3212;
			5'd2:  v = 16'sd6393;
			5'd3:  v = 16'sd9512;
			5'd4:  v = 16'sd12540;
			5'd5:  v = 16'sd15447;
			5'd6:  v = 16'sd18205;
			5'd7:  v = 16'sd20788;
			5'd8:  v = 16'sd23170;
			5'd9:  v = 16'sd25330;
			5'd10: v = 16'sd27246;
			5'd11: v = 16'sd28899;
			5'd12: v = 16'sd30274;
			5'd13: v = 16'sd31357;
			5'd14: v = 16'sd32138;
			5'd15: v = 16'sd32610;
			5'd16: v = 16'sd32767;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	// sine of 2*pi*m/64 in q1.15
	function automatic logic signed [15:0] tw_sin(input logic [5:0] m);
		logic [4:0] r;
		logic [4:0] rr;
		logic signed [15:0] v;
		r = {1'b0, m[3:0]};
		rr = 5'd16 - r;
		case (m[5:4])
			2'd0: v = quarter_sine(r);
			2'd1: v = quarter_sine(rr);
			2'd2: v = -quarter_sine(r);
			default: v = -quarter_sine(rr);
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/ofdm_cp_strip_fft_demodulator.sv */
// top level: prefix removal, symbol buffer, dft cell row and bin output
`default_nettype none
// ofdm demodulator. samples are taken one per cycle, while in_valid is high,
// as a symbol of n + p samples streams in (n = 2^fft_size_log2, p =
// prefix_length); the first p are dropped and the next n are written to the
// symbol buffer. after the last sample the buffer is read out, one sample a
// cycle, into a row of MAX_FFT cells; each sample travels one cell per cycle
// and every cell accumulates one bin with the lag-compensating twiddle folded
// in. the block then waits for the row to drain, rounds all bins at once and
// hands them out in fftshift order as n output transactions, last_bin marking
// the final one. so one symbol costs n + p input samples, a compute phase
// during which in_ready is low, and n output transactions; the row length sets
// the drain time. configuration writes are taken at any cycle and the buffer
// needs no clearing pass.
module ofdm_cp_strip_fft_demodulator #(
	parameter int MAX_FFT = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [6:0]                          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_real,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_imag,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [ocsfd_pkg::OUT_W-1:0]       bin_real,
	output logic signed [ocsfd_pkg::OUT_W-1:0]       bin_imag,
	output logic [5:0]                               subcarrier,
	output logic                                     last_bin
);
	localparam int MLG = $clog2(MAX_FFT + 1) - 1;
	localparam int AW = (MAX_FFT > 2) ? $clog2(MAX_FFT) : 1;
	localparam int WAIT_CYC = MAX_FFT + 3;

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_FEED = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	// configuration registers
	logic [2:0]        lg_q;
	logic [6:0]        prefix_q;
	logic signed [6:0] lag_q;

	logic [2:0]        state_q;
	logic [6:0]        pos_q;
	logic [6:0]        cnt_q;

	// clamped view of the configuration
	logic [2:0]        lg_c;
	logic [6:0]        n;
	logic [6:0]        p;
	logic [7:0]        len;
	logic [6:0]        off;
	logic              store;
	logic              sym_end;
	logic              in_acc;
	logic              out_acc;

	logic [2*SAMPLE_WIDTH-1:0] mem [MAX_FFT];
	logic [2*SAMPLE_WIDTH-1:0] rd_s1;
	ocsfd_pkg::tok_t           tok0_s1;
	ocsfd_pkg::cell_ctl_t      ctl;

	ocsfd_pkg::tok_t                    tok_c   [MAX_FFT];
	logic signed [SAMPLE_WIDTH-1:0]     re_c    [MAX_FFT];
	logic signed [SAMPLE_WIDTH-1:0]     im_c    [MAX_FFT];
	logic signed [ocsfd_pkg::OUT_W-1:0] res_re_c [MAX_FFT+1];
	logic signed [ocsfd_pkg::OUT_W-1:0] res_im_c [MAX_FFT+1];

	always_comb begin
		if (lg_q == 3'd0) lg_c = 3'd1;
		else if (lg_q > 3'(MLG)) lg_c = 3'(MLG);
		else lg_c = lg_q;
		n = 7'd1 << lg_c;
		p = (prefix_q > ocsfd_pkg::PREFIX_MAX) ? ocsfd_pkg::PREFIX_MAX : prefix_q;
		len = {1'b0, n} + {1'b0, p};
		off = pos_q - p;
		store = (pos_q >= p) && (off < n);
		sym_end = ({1'b0, pos_q} + 8'd1) >= len;
	end

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_COLLECT);
	assign in_acc = in_valid & in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= 3'd6;
			prefix_q <= 7'd16;
			lag_q <= 7'sd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ocsfd_pkg::CFG_SIZE:   lg_q <= cfg_data[2:0];
				ocsfd_pkg::CFG_PREFIX: prefix_q <= cfg_data;
				ocsfd_pkg::CFG_LAG:    lag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// symbol sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			pos_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						if (sym_end) begin
							pos_q <= '0;
							cnt_q <= '0;
							state_q <= ST_FEED;
						end else begin
							pos_q <= pos_q + 7'd1;
						end
					end
				end
				ST_FEED: begin
					if (cnt_q == n - 7'd1) begin
						cnt_q <= '0;
						state_q <= ST_WAIT;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_WAIT: begin
					if (cnt_q == 7'(WAIT_CYC)) begin
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_LOAD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_acc) begin
						if (cnt_q == n - 7'd1) begin
							cnt_q <= '0;
							state_q <= ST_COLLECT;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	// token for the first cell, in step with the buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_s1 <= '0;
		end else begin
			tok0_s1 <= '{valid: (state_q == ST_FEED), first: (cnt_q == 7'd0),
				t: cnt_q[5:0]};
		end
	end

	// symbol buffer, real part in the low half
	always_ff @(posedge clk) begin
		if (in_acc && store) mem[off[AW-1:0]] <= {sample_imag, sample_real};
		rd_s1 <= mem[cnt_q[AW-1:0]];
	end

	always_comb begin
		ctl.n = n;
		ctl.lg = lg_c;
		ctl.lag = lag_q;
		ctl.load = (state_q == ST_LOAD);
		ctl.shift = out_acc;
	end

	assign tok_c[0] = tok0_s1;
	assign re_c[0] = rd_s1[SAMPLE_WIDTH-1:0];
	assign im_c[0] = rd_s1[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	assign res_re_c[MAX_FFT] = '0;
	assign res_im_c[MAX_FFT] = '0;

	// row of dft cells, samples move one cell per cycle
	for (genvar i = 0; i < MAX_FFT; i++) begin : g_cell
		if (i < MAX_FFT - 1) begin : g_mid
			ocsfd_cell #(.INDEX(i), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.tok_in(tok_c[i]), .re_in(re_c[i]), .im_in(im_c[i]),
				.res_re_in(res_re_c[i+1]), .res_im_in(res_im_c[i+1]),
				.tok_out(tok_c[i+1]), .re_out(re_c[i+1]), .im_out(im_c[i+1]),
				.res_re(res_re_c[i]), .res_im(res_im_c[i])
			);
		end else begin : g_end
			ocsfd_cell #(.INDEX(i), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.tok_in(tok_c[i]), .re_in(re_c[i]), .im_in(im_c[i]),
				.res_re_in(res_re_c[i+1]), .res_im_in(res_im_c[i+1]),
				.tok_out(), .re_out(), .im_out(),
				.res_re(res_re_c[i]), .res_im(res_im_c[i])
			);
		end
	end

	// cell zero holds the bin on offer
	assign bin_real = res_re_c[0];
	assign bin_imag = res_im_c[0];
	assign subcarrier = cnt_q[5:0];
	assign last_bin = (cnt_q == n - 7'd1);
endmodule
`default_nettype wire

/* rtl/ocsfd_cell.sv */
// one dft cell: accumulates one output bin while samples pass down the row
`default_nettype none
module ocsfd_cell #(
	parameter int INDEX = 0,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire ocsfd_pkg::cell_ctl_t                   ctl,
	input  wire ocsfd_pkg::tok_t                        tok_in,
	input  wire logic signed [SAMPLE_WIDTH-1:0]         re_in,
	input  wire logic signed [SAMPLE_WIDTH-1:0]         im_in,
	input  wire logic signed [ocsfd_pkg::OUT_W-1:0]     res_re_in,
	input  wire logic signed [ocsfd_pkg::OUT_W-1:0]     res_im_in,
	output ocsfd_pkg::tok_t                             tok_out,
	output logic signed [SAMPLE_WIDTH-1:0]              re_out,
	output logic signed [SAMPLE_WIDTH-1:0]              im_out,
	output logic signed [ocsfd_pkg::OUT_W-1:0]          res_re,
	output logic signed [ocsfd_pkg::OUT_W-1:0]          res_im
);
	localparam int PW = SAMPLE_WIDTH + 17;
	localparam int AW = SAMPLE_WIDTH + 23;

	logic [6:0]              n_mask;
	logic [5:0]              k6;
	logic                    active;
	logic [5:0]              tsum;
	logic [11:0]             e12;
	logic [5:0]              m6;
	logic [2:0]              sh;
	logic [5:0]              tl;
	logic signed [15:0]      sn;
	logic signed [15:0]      cs;
	logic signed [PW-1:0]    sum_re;
	logic signed [PW-1:0]    sum_im;
	logic signed [PW-1:0]    sum_re_s1;
	logic signed [PW-1:0]    sum_im_s1;
	logic                    valid_s1;
	logic                    first_s1;
	logic signed [AW-1:0]    acc_re_q;
	logic signed [AW-1:0]    acc_im_q;
	logic signed [AW-1:0]    rnd_re;
	logic signed [AW-1:0]    rnd_im;
	ocsfd_pkg::tok_t         tok_q;
	logic signed [SAMPLE_WIDTH-1:0] re_q;
	logic signed [SAMPLE_WIDTH-1:0] im_q;
	logic signed [ocsfd_pkg::OUT_W-1:0] res_re_q;
	logic signed [ocsfd_pkg::OUT_W-1:0] res_im_q;

	// bin served by this cell, fftshift order
	always_comb begin
		n_mask = ctl.n - 7'd1;
		k6 = 6'((7'(INDEX) + (ctl.n >> 1)) & n_mask);
		active = 7'(INDEX) < ctl.n;
		tsum = tok_in.t + ctl.lag[5:0];
		e12 = k6 * tsum;
		m6 = e12[5:0] & n_mask[5:0];
		sh = 3'(ocsfd_pkg::TP_LOG2) - ctl.lg;
		tl = m6 << sh;
		sn = ocsfd_pkg::tw_sin(tl);
		cs = ocsfd_pkg::tw_sin(tl + 6'd16);
		sum_re = re_in * cs + im_in * sn;
		sum_im = im_in * cs - re_in * sn;
		rnd_re = (acc_re_q + AW'(16384)) >>> 15;
		rnd_im = (acc_im_q + AW'(16384)) >>> 15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			tok_q <= tok_in;
			valid_s1 <= tok_in.valid & active;
		end
	end

	always_ff @(posedge clk) begin
		re_q <= re_in;
		im_q <= im_in;
		first_s1 <= tok_in.first;
		sum_re_s1 <= sum_re;
		sum_im_s1 <= sum_im;
		if (valid_s1) begin
			if (first_s1) begin
				acc_re_q <= AW'(sum_re_s1);
				acc_im_q <= AW'(sum_im_s1);
			end else begin
				acc_re_q <= acc_re_q + AW'(sum_re_s1);
				acc_im_q <= acc_im_q + AW'(sum_im_s1);
			end
		end
		// results leave through the row towards cell zero
		if (ctl.load) begin
			res_re_q <= ocsfd_pkg::OUT_W'(rnd_re);
			res_im_q <= ocsfd_pkg::OUT_W'(rnd_im);
		end else if (ctl.shift) begin
			res_re_q <= res_re_in;
			res_im_q <= res_im_in;
		end
	end

	assign tok_out = tok_q;
	assign re_out = re_q;
	assign im_out = im_q;
	assign res_re = res_re_q;
	assign res_im = res_im_q;
endmodule
`default_nettype wire

/* rtl/ocsfd_checker.sv */
// port-level checks on the demodulator, bound to the top level
`default_nettype none
`include "ofdm_cp_strip_fft_demodulator_macros.svh"
module ocsfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [5:0] subcarrier,
	input wire logic       last_bin
);
	// no sample taken while bins are on offer
	`OCSFD_AST_IMPL(a_no_in_during_out, out_valid, !in_ready)
	// a stalled bin stays put
	`OCSFD_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(subcarrier))
	// bins of a symbol follow one another without gaps
	`OCSFD_AST_NEXT(a_bin_step, out_valid && out_ready && !last_bin, out_valid && (subcarrier == 6'($past(subcarrier) + 6'd1)))
	// the last bin ends the burst
	`OCSFD_AST_NEXT(a_burst_end, out_valid && out_ready && last_bin, !out_valid)
endmodule

bind ofdm_cp_strip_fft_demodulator ocsfd_checker u_ocsfd_checker (.*);
`default_nettype wire

/* tb/tb_ofdm_cp_strip_fft_demodulator.sv */
// testbench for the ofdm demodulator: prefix strip, dft, lag rotation and fftshift
`default_nettype none
module tb_ofdm_cp_strip_fft_demodulator;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [ocsfd_pkg::OUT_W-1:0] re;
		logic signed [ocsfd_pkg::OUT_W-1:0] im;
		logic [5:0]                         sc;
		logic                               last;
	} bin_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] sample_real;
	logic signed [15:0] sample_imag;
	logic out_valid;
	logic out_ready;
	logic signed [ocsfd_pkg::OUT_W-1:0] bin_real;
	logic signed [ocsfd_pkg::OUT_W-1:0] bin_imag;
	logic [5:0] subcarrier;
	logic last_bin;

	ofdm_cp_strip_fft_demodulator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_real(sample_real), .sample_imag(sample_imag),
		.out_valid(out_valid), .out_ready(out_ready),
		.bin_real(bin_real), .bin_imag(bin_imag),
		.subcarrier(subcarrier), .last_bin(last_bin)
	);

	// predictor state: its own copy of the configuration and symbol store
	logic [2:0] size_log2_reg;
	logic [6:0] prefix_reg;
	logic signed [6:0] lag_reg;
	logic signed [15:0] stored_re [64];
	logic signed [15:0] stored_im [64];
	int unsigned symbol_pos;
	bin_t expected_bins [$];

	int errors;
	int samples_sent;
	int bins_seen;
	int symbols_done;
	int idle_in_pct;
	int stall_out_pct;
	int quiet_cycles;
	bit timed_out;

	localparam int WATCHDOG_LIMIT = 20000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// q1.15 twiddle sine of 2*pi*m/64, rebuilt from the quarter wave
	function automatic int twiddle_sine(input int m);
		int q;
		int r;
		int qw[17];
		qw = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
			25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};
		q = (m >> 4) & 3;
		r = m & 15;
		case (q)
			0: return qw[r];
			1: return qw[16 - r];
			2: return -qw[r];
			default: return -qw[16 - r];
		endcase
	endfunction

	// round half up to q1.15
	function automatic longint round_half_up(input longint acc);
		longint v;
		v = acc + 16384;
		return v >>> 15;
	endfunction

	// log2 of the effective fft size in use
	function automatic int fft_log2();
		if (size_log2_reg < 1) return 1;
		if (size_log2_reg > 6) return 6;
		return size_log2_reg;
	endfunction

	function automatic int prefix_eff();
		return (prefix_reg > 64) ? 64 : prefix_reg;
	endfunction

	// prefix strip and symbol end; pushes n compensated bins on completion
	task automatic demod_sample(input logic signed [15:0] xr, input logic signed [15:0] xi);
		int lg;
		int n;
		int p;
		int stride;
		int k;
		int e;
		int m;
		int tl;
		longint acc_re;
		longint acc_im;
		longint c;
		longint s;
		bin_t b;
		lg = fft_log2();
		n = 1 << lg;
		p = prefix_eff();
		if (symbol_pos >= p && symbol_pos - p < n) begin
			stored_re[(symbol_pos - p) & 63] = xr;
			stored_im[(symbol_pos - p) & 63] = xi;
		end
		if (symbol_pos + 1 < n + p) begin
			symbol_pos = (symbol_pos + 1) & 127;
			return;
		end
		symbol_pos = 0;
		symbols_done++;
		stride = 64 >> lg;
		for (int i = 0; i < n; i++) begin
			k = (i + n / 2) & (n - 1);
			acc_re = 0;
			acc_im = 0;
			for (int t = 0; t < n; t++) begin
				e = k * (t + lag_reg);
				m = e % n;
				if (m < 0) m += n;
				tl = (m * stride) & 63;
				s = twiddle_sine(tl);
				c = twiddle_sine((tl + 16) & 63);
				acc_re += stored_re[t] * c + stored_im[t] * s;
				acc_im += stored_im[t] * c - stored_re[t] * s;
			end
			b.re = ocsfd_pkg::OUT_W'(round_half_up(acc_re));
			b.im = ocsfd_pkg::OUT_W'(round_half_up(acc_im));
			b.sc = 6'(i);
			b.last = (i == n - 1);
			expected_bins.push_back(b);
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch on %s at bin %0d: got %0d, expected %0d", what, bins_seen, got,
			want);
	endtask

	// one sample transaction, with random sender idling; valid stays up afterwards
	task automatic send_sample(input logic signed [15:0] xr, input logic signed [15:0] xi);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_real <= xr;
		sample_imag <= xi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		demod_sample(xr, xi);
		samples_sent++;
	endtask

	// register write; only issued while the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ocsfd_pkg::CFG_SIZE: size_log2_reg = val[2:0];
			ocsfd_pkg::CFG_PREFIX: prefix_reg = val;
			ocsfd_pkg::CFG_LAG: lag_reg = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// full symbols; kind 0 random, 1 extremes, 2 impulse, 3 constant
	task automatic send_symbols(input int count, input int kind);
		int len;
		logic signed [15:0] xr;
		logic signed [15:0] xi;
		len = (1 << fft_log2()) + prefix_eff();
		for (int s = 0; s < count; s++)
			for (int i = 0; i < len; i++) begin
				case (kind)
					1: begin
						xr = (i[0]) ? 16'sh8000 : 16'sh7fff;
						xi = (i[1]) ? 16'sh7fff : 16'sh8000;
					end
					2: begin
						xr = (i == prefix_eff()) ? 16'sh7fff : 16'sd0;
						xi = 16'sd0;
					end
					3: begin
						xr = 16'sh8000;
						xi = 16'sh8000;
					end
					default: begin
						xr = 16'($urandom);
						xi = 16'($urandom);
					end
				endcase
				send_sample(xr, xi);
			end
	endtask

	task automatic configure(input int lg, input int p, input int lag);
		wait_drained();
		write_reg(ocsfd_pkg::CFG_SIZE, 7'(lg));
		write_reg(ocsfd_pkg::CFG_PREFIX, 7'(p));
		write_reg(ocsfd_pkg::CFG_LAG, 7'(lag));
		cfg_valid <= 1'b0;
	endtask

	// extremes on a short symbol, then an impulse and a full-scale constant
	task automatic test_directed();
		idle_in_pct = 0;
		stall_out_pct = 0;
		configure(3, 2, 0);
		send_symbols(1, 1);
		send_symbols(1, 2);
		send_symbols(1, 3);
	endtask

	// size and prefix extremes, including out-of-range register values
	task automatic test_size_extremes();
		configure(1, 0, 7'h40);
		send_symbols(2, 1);
		configure(0, 127, 0);
		send_symbols(1, 0);
		configure(7, 3, 7'h40);
		send_symbols(1, 1);
		configure(2, 0, 7'h3f);
		send_symbols(1, 0);
	endtask

	// random symbols through the idling and stalling phases, sizes kept small
	task automatic test_random_phases();
		int plan_idle[4];
		int plan_stall[4];
		plan_idle = '{0, 82, 0, 30};
		plan_stall = '{0, 0, 82, 30};
		for (int ph = 0; ph < 4; ph++) begin
			idle_in_pct = plan_idle[ph];
			stall_out_pct = plan_stall[ph];
			configure($urandom_range(1, 3), $urandom_range(0, 6), $urandom_range(0, 127));
			send_symbols(1, 0);
			// sender holds off until all bins are out
			wait_drained();
			send_symbols(1, 0);
		end
		idle_in_pct = 0;
		stall_out_pct = 0;
	endtask

	// a trailing partial symbol produces nothing
	task automatic test_partial_tail();
		configure(2, 3, 0);
		for (int i = 0; i < 5; i++) send_sample(16'($urandom), 16'($urandom));
	endtask

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_out_pct);

	// result checker
	always @(posedge clk) begin
		bin_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bins.size() == 0) begin
				report_mismatch("unexpected bin", subcarrier, -1);
			end else begin
				want = expected_bins.pop_front();
				if (bin_real !== want.re) report_mismatch("bin_real", bin_real, want.re);
				if (bin_imag !== want.im) report_mismatch("bin_imag", bin_imag, want.im);
				if (subcarrier !== want.sc) report_mismatch("subcarrier", subcarrier, want.sc);
				if (last_bin !== want.last) report_mismatch("last_bin", last_bin, want.last);
			end
			bins_seen++;
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ocsfd_pkg::CFG_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_real = '0;
		sample_imag = '0;
		out_ready = 1'b0;
		errors = 0;
		samples_sent = 0;
		bins_seen = 0;
		symbols_done = 0;
		quiet_cycles = 0;
		idle_in_pct = 0;
		stall_out_pct = 0;
		size_log2_reg = 3'd6;
		prefix_reg = 7'd16;
		lag_reg = 7'sd0;
		symbol_pos = 0;
		for (int i = 0; i < 64; i++) begin
			stored_re[i] = '0;
			stored_im[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_extremes();
		test_random_phases();
		test_partial_tail();
		wait_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d samples in %0d symbols, %0d bins checked", samples_sent,
			symbols_done, bins_seen);
		$display("sizes 2 to 64, prefixes 0 to 64, lags across range, idle and stall phases");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/ocsfd_pkg.sv
rtl/ocsfd_cell.sv
rtl/ofdm_cp_strip_fft_demodulator.sv
rtl/ocsfd_checker.sv
tb/tb_ofdm_cp_strip_fft_demodulator.sv
